/* rtl/core/i2r_pkg.sv */
// Shared types, character constants and the base decoder for the radix converter.
`timescale 1ns / 1ps

package i2r_pkg;

   // Bits per digit; zero marks a base that cannot be converted.
   typedef logic [2:0] shift_type;

   localparam shift_type SHIFT_NONE = 3'd0;
   localparam int        MAX_SHIFT  = 5;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [4:0] DEC_DIGITS = 5'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SIGN,
      ST_DIGIT,
      ST_ERROR
   } state_type;

   typedef enum logic [1:0] {
      SEL_SIGN,
      SEL_DIGIT,
      SEL_ERROR
   } char_sel_type;

   typedef struct packed {
      logic         load;
      logic         advance;
      char_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic invalid;
      logic neg;
      logic lead_zero;
      logic one_left;
   } stat_type;

   // Only 2, 4, 8, 16 and 32 are accepted; everything else maps to SHIFT_NONE.
   function automatic shift_type base_to_shift(input logic [5:0] base);
      shift_type s;
      case (base)
         6'd2:    s = 3'd1;
         6'd4:    s = 3'd2;
         6'd8:    s = 3'd3;
         6'd16:   s = 3'd4;
         6'd32:   s = 3'd5;
         default: s = SHIFT_NONE;
      endcase
      return s;
   endfunction

endpackage

/* rtl/core/int_to_pow2_radix_ascii.sv */
// Top level of the signed integer to power-of-two radix ASCII converter.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// req_      in         req_value (signed), req_base
// rsp_      out        rsp_character, rsp_last, rsp_status
//
// One request beat is taken while the block is idle. The cycle after it, the
// datapath scans the magnitude from its most significant digit, dropping one
// leading zero digit per cycle, then sends an optional '-' and one digit per
// response beat. An unsupported base gives one beat with status set. Reset
// is synchronous and only returns the controller to idle. A stalled response
// holds its beat unchanged.

module int_to_pow2_radix_ascii #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic [5:0]                    req_base,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_character,
   output logic                          rsp_last,
   output logic                          rsp_status
);

   // Commands from the controller and flags back from the datapath.
   i2r_pkg::cmd_type  cmd;
   i2r_pkg::stat_type stat;

   i2r_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the magnitude left-aligned on digit boundaries, so
   // the digit to send is always at the top of its shift register.
   i2r_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .req_value     (req_value),
      .req_base      (req_base),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status)
   );

endmodule

/* rtl/core/i2r_ctrl.sv */
// Sequencing state machine for the radix converter.
`timescale 1ns / 1ps

module i2r_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  i2r_pkg::stat_type stat,
   output i2r_pkg::cmd_type  cmd
);

   i2r_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2r_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2r_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = i2r_pkg::ST_SCAN;
            end
         end
         i2r_pkg::ST_SCAN: begin
            if (stat.invalid) begin
               state_in = i2r_pkg::ST_ERROR;
            end else if (!(stat.lead_zero && !stat.one_left)) begin
               state_in = stat.neg ? i2r_pkg::ST_SIGN : i2r_pkg::ST_DIGIT;
            end
         end
         i2r_pkg::ST_SIGN: begin
            if (rsp_ready) begin
               state_in = i2r_pkg::ST_DIGIT;
            end
         end
         i2r_pkg::ST_DIGIT: begin
            if (rsp_ready && stat.one_left) begin
               state_in = i2r_pkg::ST_IDLE;
            end
         end
         i2r_pkg::ST_ERROR: begin
            if (rsp_ready) begin
               state_in = i2r_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = i2r_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      cmd.sel     = i2r_pkg::SEL_DIGIT;
      case (state_ff)
         i2r_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         i2r_pkg::ST_SCAN: begin
            cmd.advance = !stat.invalid && stat.lead_zero && !stat.one_left;
         end
         i2r_pkg::ST_SIGN: begin
            rsp_valid = 1'b1;
            cmd.sel   = i2r_pkg::SEL_SIGN;
         end
         i2r_pkg::ST_DIGIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
         end
         i2r_pkg::ST_ERROR: begin
            rsp_valid = 1'b1;
            cmd.sel   = i2r_pkg::SEL_ERROR;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/core/i2r_dp.sv */
// Datapath of the radix converter: magnitude shifter, digit counter, character coder.
`timescale 1ns / 1ps

module i2r_dp #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic [5:0]             req_base,
   input  i2r_pkg::cmd_type       cmd,
   output i2r_pkg::stat_type      stat,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last,
   output logic                   rsp_status
);

   localparam int PAD_W = i2r_pkg::MAX_SHIFT - 1;
   localparam int WORD_W = VALUE_WIDTH + PAD_W;
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   // Digit positions for each digit size, and the zero bits added on top so
   // that the word splits into whole digits.
   localparam int POS1 = VALUE_WIDTH;
   localparam int POS2 = (VALUE_WIDTH + 1) / 2;
   localparam int POS3 = (VALUE_WIDTH + 2) / 3;
   localparam int POS4 = (VALUE_WIDTH + 3) / 4;
   localparam int POS5 = (VALUE_WIDTH + 4) / 5;
   localparam int PAD2 = POS2 * 2 - VALUE_WIDTH;
   localparam int PAD3 = POS3 * 3 - VALUE_WIDTH;
   localparam int PAD4 = POS4 * 4 - VALUE_WIDTH;
   localparam int PAD5 = POS5 * 5 - VALUE_WIDTH;

   logic [WORD_W-1:0]      word_ff, word_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   i2r_pkg::shift_type     shift_ff, shift_in;
   logic                   neg_ff, neg_in;

   logic [VALUE_WIDTH-1:0] mag;
   logic [2:0]             pad;
   logic [CNT_W-1:0]       positions;
   logic [4:0]             top_bits;
   logic [4:0]             digit;

   always_comb begin
      pad       = 3'd0;
      positions = CNT_W'(POS1);
      case (shift_in)
         3'd2: begin
            pad       = 3'(PAD2);
            positions = CNT_W'(POS2);
         end
         3'd3: begin
            pad       = 3'(PAD3);
            positions = CNT_W'(POS3);
         end
         3'd4: begin
            pad       = 3'(PAD4);
            positions = CNT_W'(POS4);
         end
         3'd5: begin
            pad       = 3'(PAD5);
            positions = CNT_W'(POS5);
         end
         default: begin
            pad       = 3'd0;
            positions = CNT_W'(POS1);
         end
      endcase
   end

   always_comb begin
      mag      = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;
      word_in  = word_ff;
      count_in = count_ff;
      shift_in = i2r_pkg::base_to_shift(req_base);
      neg_in   = req_value[VALUE_WIDTH-1];
      if (cmd.load) begin
         word_in  = {mag, PAD_W'(0)} >> pad;
         count_in = positions;
      end else begin
         shift_in = shift_ff;
         neg_in   = neg_ff;
         if (cmd.advance) begin
            word_in  = word_ff << shift_ff;
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      count_ff <= count_in;
      shift_ff <= shift_in;
      neg_ff   <= neg_in;
   end

   // The current digit sits in the top shift_ff bits of the word.
   assign top_bits = word_ff[WORD_W-1 -: i2r_pkg::MAX_SHIFT];
   assign digit    = top_bits >> (3'(i2r_pkg::MAX_SHIFT) - shift_ff);

   assign stat.invalid   = (shift_ff == i2r_pkg::SHIFT_NONE);
   assign stat.neg       = neg_ff;
   assign stat.lead_zero = (digit == 5'd0);
   assign stat.one_left  = (count_ff == CNT_W'(1));

   always_comb begin
      rsp_character = i2r_pkg::CHAR_NUL;
      rsp_last      = 1'b0;
      rsp_status    = 1'b0;
      case (cmd.sel)
         i2r_pkg::SEL_SIGN: begin
            rsp_character = i2r_pkg::CHAR_MINUS;
         end
         i2r_pkg::SEL_DIGIT: begin
            if (digit < i2r_pkg::DEC_DIGITS) begin
               rsp_character = i2r_pkg::CHAR_ZERO + {3'b000, digit};
            end else begin
               rsp_character = i2r_pkg::CHAR_UPPER + {3'b000, digit}
                               - {3'b000, i2r_pkg::DEC_DIGITS};
            end
            rsp_last = stat.one_left;
         end
         i2r_pkg::SEL_ERROR: begin
            rsp_last   = 1'b1;
            rsp_status = 1'b1;
         end
         default: begin
            rsp_character = i2r_pkg::CHAR_NUL;
         end
      endcase
   end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the power-of-two radix ASCII converter.
`timescale 1ns / 1ps

module tb;

   localparam int VALUE_WIDTH = 32;

   // Status codes carried on every response beat.
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_BASE = 1'b1;

   // Number of mismatches that are printed in full; later ones are only counted.
   localparam int SHOW_LIMIT = 10;

   // One expected response beat.
   typedef struct packed {
      logic [7:0] character;
      logic       last;
      logic       status;
   } char_beat_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic [5:0]                    req_base = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [7:0]                    rsp_character;
   logic                          rsp_last;
   logic                          rsp_status;

   // Characters that the converter still owes, oldest first.
   char_beat_type pending_chars[$];
   int            error_count = 0;

   // The sender works in bursts; this counts the beats left in the current one.
   int burst_left = 0;

   int_to_pow2_radix_ascii #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_base     (req_base),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status)
   );

   // A 4 ns clock: two ns high, two ns low.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Spells one value in the given base and appends the characters it should
   // produce to the pending queue. Bases that are not a power of two between
   // 2 and 32 produce a single error beat instead. The magnitude is taken in
   // unsigned arithmetic, so the most negative value becomes 2^(width-1).
   function automatic void spell_in_base(input logic signed [VALUE_WIDTH-1:0] value,
                                         input logic [5:0] base);
      int                     shift;
      int                     ndig;
      int                     i;
      logic [VALUE_WIDTH-1:0] mag;
      logic [VALUE_WIDTH-1:0] digit;
      char_beat_type          beat;
      if (base < 6'd2 || (base & (base - 6'd1)) != 6'd0) begin
         beat = '{character: i2r_pkg::CHAR_NUL, last: 1'b1, status: STATUS_BAD_BASE};
         pending_chars.push_back(beat);
         return;
      end
      shift = 0;
      while ((1 << shift) != int'(base))
         shift++;
      mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      // Zero still gets one digit.
      ndig = 1;
      while (shift * ndig < VALUE_WIDTH && (mag >> (shift * ndig)) != '0)
         ndig++;
      if (value[VALUE_WIDTH-1]) begin
         beat = '{character: i2r_pkg::CHAR_MINUS, last: 1'b0, status: STATUS_OK};
         pending_chars.push_back(beat);
      end
      for (i = ndig; i > 0; i--) begin
         digit = (mag >> (shift * (i - 1))) & VALUE_WIDTH'(base - 6'd1);
         if (digit < VALUE_WIDTH'(i2r_pkg::DEC_DIGITS))
            beat.character = i2r_pkg::CHAR_ZERO + digit[7:0];
         else
            beat.character = i2r_pkg::CHAR_UPPER + digit[7:0] - 8'(i2r_pkg::DEC_DIGITS);
         beat.last   = (i == 1);
         beat.status = STATUS_OK;
         pending_chars.push_back(beat);
      end
   endfunction

   // Both channels are observed at the falling edge, where every signal is
   // settled; a beat seen there is taken at the following rising edge. The
   // request side is handled first, so a response in the same cycle always
   // finds its expectation already queued.
   always @(negedge clock) begin
      char_beat_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            spell_in_base(req_value, req_base);
         if (rsp_valid && rsp_ready) begin
            if (pending_chars.size() == 0) begin
               error_count++;
               if (error_count <= SHOW_LIMIT)
                  $display("tb: unexpected beat char=%02h last=%0d status=%0d",
                           rsp_character, rsp_last, rsp_status);
            end else begin
               want = pending_chars.pop_front();
               if (rsp_character !== want.character || rsp_last !== want.last ||
                   rsp_status !== want.status) begin
                  error_count++;
                  if (error_count <= SHOW_LIMIT) begin
                     $write("tb: mismatch expected char=%02h last=%0d status=%0d,",
                            want.character, want.last, want.status);
                     $display(" got char=%02h last=%0d status=%0d",
                              rsp_character, rsp_last, rsp_status);
                  end
               end
            end
         end
      end
   end

   // The receiver stalls on a pattern of its own that it picks anew periodically:
   // always ready, a light or heavy random stall, or a repeating 8-bit mask.
   // Being always ready gives stretches with no stall at all.
   int       stall_mode = 0;
   int       stall_tick = 0;
   logic [7:0] stall_mask = 8'hFF;

   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 150 == 149) begin
         stall_mode <= $urandom_range(0, 3);
         stall_mask <= 8'($urandom_range(1, 255));
      end
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= ($urandom_range(0, 99) < 85);
         end
         2: begin
            rsp_ready <= ($urandom_range(0, 99) < 40);
         end
         default: begin
            rsp_ready <= stall_mask[3'(stall_tick)];
         end
      endcase
   end

   // Sends one request beat. Called at a rising edge; returns at the rising
   // edge where the beat is taken. Within this task, valid is only lowered when a
   // gap between bursts begins, so it never drops and rises in the same step.
   task automatic send_item(input logic signed [VALUE_WIDTH-1:0] value,
                            input logic [5:0] base);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // Mostly short bursts, now and then a long back-to-back run.
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 4);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value <= value;
      req_base  <= base;
      forever begin
         @(negedge clock);
         if (req_ready)
            break;
      end
      @(posedge clock);
   endtask

   // Holds the request channel quiet until every owed character has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(posedge clock);
      burst_left = 0;
   endtask

   // A random base: mostly one of the five legal radices, sometimes any
   // 6-bit code, which is then usually illegal.
   function automatic logic [5:0] pick_base();
      logic [5:0] legal[5] = '{6'd2, 6'd4, 6'd8, 6'd16, 6'd32};
      if ($urandom_range(0, 99) < 80)
         return legal[3'($urandom_range(0, 4))];
      return 6'($urandom_range(0, 63));
   endfunction

   // A random value drawn from several shapes: any 32-bit word, a small
   // number, a power of two or one less (the points where the digit count
   // changes), or one of the extremes. Most shapes are negated half the time.
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      logic signed [VALUE_WIDTH-1:0] v;
      int                            k;
      case ($urandom_range(0, 3))
         0: v = VALUE_WIDTH'($urandom);
         1: v = VALUE_WIDTH'($urandom_range(0, 40));
         2: begin
            k = $urandom_range(0, VALUE_WIDTH - 2);
            v = (VALUE_WIDTH'(1) << k) - VALUE_WIDTH'($urandom_range(0, 1));
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
               1:       v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
               2:       v = '0;
               default: v = '1;
            endcase
            return v;
         end
      endcase
      if ($urandom_range(0, 1) == 1)
         v = -v;
      return v;
   endfunction

   // Zero, -1, the largest and the most negative value in every legal base,
   // a value that uses many letter digits, and a spread of illegal bases
   // (0, 1, a non-power of two, 36 and the all-ones code).
   task automatic test_directed_extremes();
      logic [5:0] legal[5] = '{6'd2, 6'd4, 6'd8, 6'd16, 6'd32};
      int         i;
      for (i = 0; i < 5; i++) begin
         send_item('0, legal[3'(i)]);
         send_item('1, legal[3'(i)]);
         send_item({1'b0, {(VALUE_WIDTH-1){1'b1}}}, legal[3'(i)]);
         send_item({1'b1, {(VALUE_WIDTH-1){1'b0}}}, legal[3'(i)]);
      end
      send_item(32'h5EF7BDEF, 6'd32);
      send_item(32'h1234, 6'd0);
      send_item(32'h1234, 6'd1);
      send_item(-32'sd77, 6'd3);
      send_item(32'h1234, 6'd36);
      send_item(32'h1234, 6'd63);
   endtask

   // The bulk of the random stimulus, with the sender's bursts and the
   // receiver's stall patterns running freely.
   task automatic test_random_mixed(input int count);
      int i;
      for (i = 0; i < count; i++)
         send_item(pick_value(), pick_base());
   endtask

   // Random beats with a full drain in the middle, so the converter goes idle
   // and is restarted from an empty pipeline.
   task automatic test_drain_pause(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i == count / 2)
            wait_for_drain();
         send_item(pick_value(), pick_base());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_random_mixed(105);
      test_drain_pause(40);

      req_valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(posedge clock);
      // Leave room for any stray beat to show up and be flagged.
      repeat (40) @(posedge clock);

      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Hard limit, several times the slowest legal run.
   initial begin
      #2000000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/i2r_pkg.sv
rtl/core/i2r_ctrl.sv
rtl/core/i2r_dp.sv
rtl/core/int_to_pow2_radix_ascii.sv
tb/sv/tb.sv
